@@ hdl/bda_pkg.sv @@
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants of the buddy allocator
// Pool geometry, list storage layout, datapath commands and status bundles.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int POOL_ORDER = 10;
	localparam int NUM_ORDERS = POOL_ORDER + 1;
	localparam int LIST_CAP   = 1 << (POOL_ORDER - 1);
	localparam int POOL_UNITS = 1 << POOL_ORDER;
	localparam int ORD_W      = 4;
	localparam int IDX_W      = POOL_ORDER - 1;
	localparam int CNT_W      = IDX_W + 1;
	localparam int OFF_W      = 10;
	localparam int SIZE_W     = 11;
	localparam int ADDR_W     = ORD_W + IDX_W;
	localparam int MEM_DEPTH  = NUM_ORDERS * LIST_CAP;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DECODE,
		CMD_SEARCH_NEXT,
		CMD_POP,
		CMD_POP_CAP,
		CMD_SPLIT,
		CMD_ALLOC_OK,
		CMD_FAIL,
		CMD_SCAN_RD,
		CMD_SCAN_NEXT,
		CMD_SHIFT_RD,
		CMD_SHIFT_WR,
		CMD_TAKE_DONE,
		CMD_PUSH_FREE,
		CMD_OUT
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} dp_cmd_t;

	typedef struct packed {
		logic op;
		logic req_bad;
		logic ord_top;
		logic search_end;
		logic cnt_zero;
		logic s_gt_ord;
		logic match;
		logic idx_end;
		logic shift_last;
		logic next_top;
		logic out_full;
	} dp_status_t;

	// Bit length of (size - 1): the order that holds a block of this size.
	function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] m;
		logic [ORD_W-1:0] r;
		m = size - SIZE_W'(1);
		r = '0;
		if (size == '0) begin
			m = '0;
		end
		for (int b = 0; b < SIZE_W; b++) begin
			if (m[b]) begin
				r = ORD_W'(b + 1);
			end
		end
		return r;
	endfunction

endpackage

@@ hdl/bda_ctrl.sv @@
// ----------------------------------------------------------------------------
// bda_ctrl: request sequencer of the buddy allocator
// Walks the order search, block split, buddy scan and list compaction steps.
// ----------------------------------------------------------------------------
module bda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  bda_pkg::dp_status_t st,
	output bda_pkg::dp_cmd_t    cmd
);
	import bda_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b000000000001,
		ST_DECODE   = 12'b000000000010,
		ST_SEARCH   = 12'b000000000100,
		ST_POPCAP   = 12'b000000001000,
		ST_SPLIT    = 12'b000000010000,
		ST_SCAN_RD  = 12'b000000100000,
		ST_SCAN_CMP = 12'b000001000000,
		ST_SHIFT_RD = 12'b000010000000,
		ST_SHIFT_WR = 12'b000100000000,
		ST_PUSH     = 12'b001000000000,
		ST_FINISH   = 12'b010000000000,
		ST_SPARE    = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.cmd = CMD_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.cmd = CMD_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (st.req_bad) begin
					cmd.cmd = CMD_FAIL;
					state_d = ST_FINISH;
				end else begin
					cmd.cmd = CMD_DECODE;
					if (st.op == OP_ALLOC) begin
						state_d = ST_SEARCH;
					end else if (st.ord_top) begin
						state_d = ST_PUSH;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_SEARCH: begin
				if (st.search_end) begin
					cmd.cmd = CMD_FAIL;
					state_d = ST_FINISH;
				end else if (st.cnt_zero) begin
					cmd.cmd = CMD_SEARCH_NEXT;
				end else begin
					cmd.cmd = CMD_POP;
					state_d = ST_POPCAP;
				end
			end
			ST_POPCAP: begin
				cmd.cmd = CMD_POP_CAP;
				state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				if (st.s_gt_ord) begin
					cmd.cmd = CMD_SPLIT;
				end else begin
					cmd.cmd = CMD_ALLOC_OK;
					state_d = ST_FINISH;
				end
			end
			ST_SCAN_RD: begin
				if (st.idx_end) begin
					state_d = ST_PUSH;
				end else begin
					cmd.cmd = CMD_SCAN_RD;
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (st.match) begin
					state_d = ST_SHIFT_RD;
				end else begin
					cmd.cmd = CMD_SCAN_NEXT;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SHIFT_RD: begin
				if (st.shift_last) begin
					// The buddy is gone; carry on one order up with the merged block.
					cmd.cmd = CMD_TAKE_DONE;
					state_d = st.next_top ? ST_PUSH : ST_SCAN_RD;
				end else begin
					cmd.cmd = CMD_SHIFT_RD;
					state_d = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				cmd.cmd = CMD_SHIFT_WR;
				state_d = ST_SHIFT_RD;
			end
			ST_PUSH: begin
				cmd.cmd = CMD_PUSH_FREE;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!st.out_full) begin
					cmd.cmd = CMD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/bda_dpath.sv @@
// ----------------------------------------------------------------------------
// bda_dpath: datapath of the buddy allocator
// Free-list storage, per-order counts, free-unit tracking and result register.
// ----------------------------------------------------------------------------
module bda_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bda_pkg::dp_cmd_t                  cmd,
	output bda_pkg::dp_status_t               st,
	input  logic                              in_op,
	input  logic [bda_pkg::SIZE_W-1:0]        in_size,
	input  logic [bda_pkg::OFF_W-1:0]         in_offset,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bda_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import bda_pkg::*;

	localparam logic [ADDR_W-1:0] TOP_ADDR = {ORD_W'(POOL_ORDER), IDX_W'(0)};

	logic [OFF_W-1:0]  mem [0:MEM_DEPTH-1];
	logic [OFF_W-1:0]  mem_rd_q;
	logic              rd_zero_q;
	logic              top_init_q;
	logic [CNT_W-1:0]  cnt_q [0:NUM_ORDERS-1];
	logic [SIZE_W-1:0] fu_q;

	logic              op_q;
	logic [SIZE_W-1:0] rsz_q;
	logic [ORD_W-1:0]  ord_q;
	logic [ORD_W-1:0]  s_q;
	logic [OFF_W-1:0]  off_q;
	logic [CNT_W-1:0]  idx_q;

	logic              res_status_q;
	logic [OFF_W-1:0]  res_goff_q;
	logic [SIZE_W-1:0] res_gsize_q;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [ORD_W-1:0]  ord_calc;
	logic [CNT_W-1:0]  cnt_cur;
	logic [OFF_W-1:0]  rdata;
	logic [OFF_W-1:0]  bud;
	logic [SIZE_W-1:0] size_m1;
	logic              bad_alloc, bad_free;

	logic              rd_en;
	logic [ADDR_W-1:0] raddr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [OFF_W-1:0]  wdata;
	logic              push_en;
	logic [ORD_W-1:0]  push_ord;
	logic [OFF_W-1:0]  push_off;
	logic [CNT_W-1:0]  push_cnt;
	logic [ORD_W-1:0]  s_dn;
	logic [SIZE_W:0]   fu_sum;

	assign ord_calc = size_order(rsz_q);
	assign size_m1  = rsz_q - SIZE_W'(1);
	assign cnt_cur  = (s_q <= ORD_W'(POOL_ORDER)) ? cnt_q[s_q] : '0;
	assign rdata    = rd_zero_q ? '0 : mem_rd_q;
	assign bud      = off_q ^ (OFF_W'(1) << s_q);
	assign s_dn     = s_q - ORD_W'(1);

	assign bad_alloc = rsz_q > SIZE_W'(POOL_UNITS);
	assign bad_free  = (rsz_q == '0) || ((rsz_q & size_m1) != '0)
		|| (rsz_q > SIZE_W'(POOL_UNITS)) || ((off_q & size_m1[OFF_W-1:0]) != '0);

	assign st.op         = op_q;
	assign st.req_bad    = (op_q == OP_ALLOC) ? bad_alloc : bad_free;
	assign st.ord_top    = (ord_calc == ORD_W'(POOL_ORDER));
	assign st.search_end = (s_q > ORD_W'(POOL_ORDER));
	assign st.cnt_zero   = (cnt_cur == '0);
	assign st.s_gt_ord   = (s_q > ord_q);
	assign st.match      = (rdata == bud);
	assign st.idx_end    = (idx_q == cnt_cur);
	assign st.shift_last = ((idx_q + CNT_W'(1)) == cnt_cur);
	assign st.next_top   = (s_q == ORD_W'(POOL_ORDER - 1));
	assign st.out_full   = out_valid_q && !m_tready;

	// Read port.
	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		unique case (cmd.cmd)
			CMD_POP: begin
				rd_en = 1'b1;
				raddr = {s_q, IDX_W'(cnt_cur - CNT_W'(1))};
			end
			CMD_SCAN_RD: begin
				rd_en = 1'b1;
				raddr = {s_q, idx_q[IDX_W-1:0]};
			end
			CMD_SHIFT_RD: begin
				rd_en = 1'b1;
				raddr = {s_q, IDX_W'(idx_q + CNT_W'(1))};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Push and write port.
	always_comb begin
		push_en  = 1'b0;
		push_ord = s_q;
		push_off = off_q;
		if (cmd.cmd == CMD_SPLIT) begin
			push_en  = 1'b1;
			push_ord = s_dn;
			push_off = off_q + (OFF_W'(1) << s_dn);
		end else if (cmd.cmd == CMD_PUSH_FREE) begin
			push_en = 1'b1;
		end
		push_cnt = cnt_q[push_ord];
		we    = 1'b0;
		waddr = {push_ord, push_cnt[IDX_W-1:0]};
		wdata = push_off;
		if (push_en && !push_cnt[CNT_W-1]) begin
			we = 1'b1;
		end else if (cmd.cmd == CMD_SHIFT_WR) begin
			we    = 1'b1;
			waddr = {s_q, idx_q[IDX_W-1:0]};
			wdata = rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			mem_rd_q <= mem[raddr];
		end
	end

	// The initial top-order block at offset zero was never written to storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_init_q <= 1'b0;
			rd_zero_q  <= 1'b0;
		end else begin
			if (we && waddr == TOP_ADDR) begin
				top_init_q <= 1'b1;
			end
			if (rd_en) begin
				rd_zero_q <= (raddr == TOP_ADDR) && !top_init_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ORDERS; i++) begin
				cnt_q[i] <= (i == POOL_ORDER) ? CNT_W'(1) : '0;
			end
		end else begin
			if (push_en && !push_cnt[CNT_W-1]) begin
				cnt_q[push_ord] <= push_cnt + CNT_W'(1);
			end
			if (cmd.cmd == CMD_POP || cmd.cmd == CMD_TAKE_DONE) begin
				cnt_q[s_q] <= cnt_cur - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.cmd)
			CMD_LOAD: begin
				op_q  <= in_op;
				rsz_q <= in_size;
				off_q <= in_offset;
				idx_q <= '0;
			end
			CMD_DECODE: begin
				ord_q <= ord_calc;
				s_q   <= ord_calc;
			end
			CMD_SEARCH_NEXT: s_q <= s_q + ORD_W'(1);
			CMD_POP_CAP: off_q <= rdata;
			CMD_SPLIT: s_q <= s_dn;
			CMD_SCAN_NEXT: idx_q <= idx_q + CNT_W'(1);
			CMD_SHIFT_WR: idx_q <= idx_q + CNT_W'(1);
			CMD_TAKE_DONE: begin
				if (bud < off_q) begin
					off_q <= bud;
				end
				s_q   <= s_q + ORD_W'(1);
				idx_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign fu_sum = {1'b0, fu_q} + {1'b0, rsz_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fu_q <= SIZE_W'(POOL_UNITS);
		end else if (cmd.cmd == CMD_ALLOC_OK) begin
			fu_q <= (fu_q >= (SIZE_W'(1) << ord_q)) ? fu_q - (SIZE_W'(1) << ord_q) : '0;
		end else if (cmd.cmd == CMD_PUSH_FREE) begin
			fu_q <= (fu_sum > (SIZE_W + 1)'(POOL_UNITS)) ? SIZE_W'(POOL_UNITS)
				: fu_sum[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.cmd)
			CMD_ALLOC_OK: begin
				res_status_q <= 1'b0;
				res_goff_q   <= off_q;
				res_gsize_q  <= SIZE_W'(1) << ord_q;
			end
			CMD_FAIL: begin
				res_status_q <= 1'b1;
				res_goff_q   <= '0;
				res_gsize_q  <= '0;
			end
			CMD_PUSH_FREE: begin
				res_status_q <= 1'b0;
				res_goff_q   <= '0;
				res_gsize_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.cmd == CMD_OUT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmd == CMD_OUT) begin
			out_data_q <= {7'b0, fu_q, res_gsize_q, res_goff_q, res_status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ hdl/buddy_allocator_core.sv @@
// ----------------------------------------------------------------------------
// buddy_allocator_core: binary buddy allocator over a 1024-unit pool
// Usage: requests enter on the s_ stream (tuser selects allocate or free,
// tdata carries the size and, for a free, the block offset). One result per
// request leaves on the m_ stream with status, granted offset and size, and
// the free unit count after the request.
// Requests are handled one at a time. An allocate searches upward past empty
// orders (failing if none is left), pops a block and splits it down one order
// per step, pushing each upper half onto its list. A free scans each order's
// list for the buddy one entry at a time; on a match it moves later entries
// down to close the gap, drops the buddy and goes one order up with the merged
// block, then pushes the block where it stops. A rejected request skips to its
// result; the next request is taken once that result is registered.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is already being worked on, and only the hand-off
// of that next result waits.
// After reset the pool is one free block of 1024 units at offset zero and
// the block accepts a request as soon as reset is released.
// ----------------------------------------------------------------------------
module buddy_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // request_size[10:0], block_offset[20:11], zero fill
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // status, granted_offset, granted_size, free_units
);
	import bda_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	bda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bda_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_op     (s_tuser),
		.in_size   (s_tdata[SIZE_W-1:0]),
		.in_offset (s_tdata[SIZE_W+OFF_W-1:SIZE_W]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
